// ===== rtl/bflb_pkg.sv =====
// Shared constants, register indexes and types for the bitmap first/last bit search.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package bflb_pkg;

  localparam int WORD_BITS  = 32;
  localparam int MAX_BITS   = 1024;

  // Derived widths.
  localparam int WORD_IDX_W = $clog2(WORD_BITS);
  localparam int POS_W      = $clog2(MAX_BITS);
  localparam int LEN_W      = POS_W + 1;
  localparam int CNT_W      = POS_W - WORD_IDX_W;
  localparam int WORDS_W    = CNT_W + 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = LEN_W;
  localparam int MODE_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BIT_LENGTH  = CFG_IDX_W'(1);

  localparam logic [MODE_W-1:0] MODE_RESET = MODE_W'(0);
  localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(MAX_BITS);

  // Meaning of the search mode bits.
  localparam int MODE_INVERT_BIT = 0;  // search for clear bits
  localparam int MODE_LAST_BIT   = 1;  // search from the top down

  // Result of scanning one word.
  typedef struct packed {
    logic             hit;   // a matching bit lies in this word
    logic [POS_W-1:0] pos;   // its position across the whole bitmap
    logic             last;  // this word ends the bitmap
  } scan_t;

endpackage

// ===== rtl/bflb_ifs.sv =====
// Handshake channel interfaces: bitmap words in, search results out, register writes.
// Depends on bflb_pkg for widths.
`timescale 1ns / 1ps

interface bflb_in_if import bflb_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] bitmap_word;

  modport source (output valid, output bitmap_word, input ready);
  modport sink   (input valid, input bitmap_word, output ready);
endinterface

interface bflb_out_if import bflb_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [LEN_W-1:0] bit_position;
  logic                    found;

  modport source (output valid, output bit_position, output found, input ready);
  modport sink   (input valid, input bit_position, input found, output ready);
endinterface

interface bflb_cfg_if import bflb_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/bflb_word_scan.sv =====
// Combinational scan of one bitmap word: length mask, optional inversion, priority encode.
// Depends on bflb_pkg for widths, mode bits and scan_t.
`timescale 1ns / 1ps

module bflb_word_scan import bflb_pkg::*; (
  input  logic [WORD_BITS-1:0] word,
  input  logic [MODE_W-1:0]    mode,
  input  logic [LEN_W-1:0]     bit_length,
  input  logic [CNT_W-1:0]     word_count,
  output scan_t                scan
);

  function automatic logic [WORD_IDX_W-1:0] lowest_one(input logic [WORD_BITS-1:0] t);
    logic [WORD_IDX_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (t[i]) idx = WORD_IDX_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [WORD_IDX_W-1:0] highest_one(input logic [WORD_BITS-1:0] t);
    logic [WORD_IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (t[i]) idx = WORD_IDX_W'(i);
    end
    return idx;
  endfunction

  logic [LEN_W-1:0]      len;
  logic [LEN_W-1:0]      len_round;
  logic [WORDS_W-1:0]    words;
  logic [LEN_W-1:0]      base;
  logic [LEN_W-1:0]      remain;
  logic [WORD_BITS-1:0]  mask;
  logic [WORD_BITS-1:0]  target;
  logic [WORD_IDX_W-1:0] idx;

  always_comb begin
    // A length of zero or beyond the maximum means the full bitmap.
    if (bit_length == '0 || bit_length > LEN_W'(MAX_BITS)) begin
      len = LEN_W'(MAX_BITS);
    end else begin
      len = bit_length;
    end
    len_round = len + LEN_W'(WORD_BITS - 1);
    words     = len_round[LEN_W-1:WORD_IDX_W];

    base   = {1'b0, word_count, {WORD_IDX_W{1'b0}}};
    remain = len - base;
    if (base >= len) begin
      mask = '0;
    end else if (remain >= LEN_W'(WORD_BITS)) begin
      mask = '1;
    end else begin
      mask = ~({WORD_BITS{1'b1}} << remain[WORD_IDX_W-1:0]);
    end

    target = (mode[MODE_INVERT_BIT] ? ~word : word) & mask;
    idx    = mode[MODE_LAST_BIT] ? highest_one(target) : lowest_one(target);

    scan.hit  = (target != '0);
    // The word base is a multiple of the word size, so the position is a concatenation.
    scan.pos  = {word_count, idx};
    scan.last = ({1'b0, word_count} + WORDS_W'(1)) >= words;
  end

endmodule

// ===== rtl/bitmap_first_last_bit_search.sv =====
// Top level of the bitmap first/last bit search: input register, search state, result register.
// Depends on bflb_pkg, the channel interfaces in bflb_ifs and bflb_word_scan.
//
//   Channel     Direction  Payload                     Moves
//   bitmap_in   in         bitmap_word[31:0]           one item per bitmap word
//   result_out  out        bit_position[10:0], found   one item per finished bitmap
//   cfg         in         index[3:0], data[10:0]      one register write
//
// A word is registered on acceptance and scanned in the next cycle; the result of
// the final word is then registered in the output register. One word is taken every
// cycle unless the output register stalls the scan stage, which it does only while
// it holds a result that has not been taken. Reset clears the search state and sets
// search_mode to 0 and bit_length to 1024; config writes are always taken.
`timescale 1ns / 1ps

module bitmap_first_last_bit_search import bflb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  bflb_in_if.sink    bitmap_in,
  bflb_out_if.source result_out,
  bflb_cfg_if.sink   cfg
);

  logic [MODE_W-1:0] search_mode;
  logic [LEN_W-1:0]  bit_length;

  logic                 s1_valid;
  logic [WORD_BITS-1:0] s1_word;
  logic                 s1_advance;
  logic                 s1_fire;

  logic [CNT_W-1:0] word_counter;
  logic             hit_seen;
  logic [POS_W-1:0] best_position;
  logic             hit_seen_next;
  logic [POS_W-1:0] best_position_next;

  logic                    out_valid;
  logic signed [LEN_W-1:0] out_position;
  logic                    out_found;

  scan_t scan;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_mode <= MODE_RESET;
      bit_length  <= LEN_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SEARCH_MODE: search_mode <= cfg.data[MODE_W-1:0];
        REG_BIT_LENGTH:  bit_length  <= cfg.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  assign s1_advance      = !out_valid || result_out.ready;
  assign s1_fire         = s1_valid && s1_advance;
  assign bitmap_in.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bitmap_in.valid && bitmap_in.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bitmap_in.valid && bitmap_in.ready) begin
      s1_word <= bitmap_in.bitmap_word;
    end
  end

  bflb_word_scan u_scan (
    .word       (s1_word),
    .mode       (search_mode),
    .bit_length (bit_length),
    .word_count (word_counter),
    .scan       (scan)
  );

  // A first search keeps its earliest hit; a last search lets a later hit replace it.
  always_comb begin
    hit_seen_next      = hit_seen;
    best_position_next = best_position;
    if (scan.hit && (search_mode[MODE_LAST_BIT] || !hit_seen)) begin
      hit_seen_next      = 1'b1;
      best_position_next = scan.pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_counter  <= '0;
      hit_seen      <= 1'b0;
      best_position <= '0;
    end else if (s1_fire) begin
      if (scan.last) begin
        word_counter  <= '0;
        hit_seen      <= 1'b0;
        best_position <= '0;
      end else begin
        word_counter  <= word_counter + CNT_W'(1);
        hit_seen      <= hit_seen_next;
        best_position <= best_position_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && scan.last) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && scan.last) begin
      out_found    <= hit_seen_next;
      out_position <= hit_seen_next ? $signed({1'b0, best_position_next}) : '1;
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.bit_position = out_position;
  assign result_out.found        = out_found;

  // The final word of a bitmap leaves the search state cleared for the next one.
  a_state_clears: assert property (@(posedge clk) disable iff (rst)
    s1_fire && scan.last |=> word_counter == '0 && !hit_seen)
    else $error("search state not cleared after the final word");

  // A found position is never negative and a miss always reads as minus one.
  a_result_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_found && !out_position[LEN_W-1]) || (!out_found && out_position == '1))
    else $error("result position disagrees with found flag");

  // Input is refused only while a word waits behind an unread result.
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !bitmap_in.ready |-> s1_valid && out_valid && !result_out.ready)
    else $error("input refused without a stall");

endmodule

// ===== tb/tb_bitmap_first_last_bit_search.sv =====
// Testbench for bitmap_first_last_bit_search: streams bitmaps with random handshake gaps
// and checks every search result against a predictor kept in step with each accepted word.
// Depends on bflb_pkg, the channel interfaces in bflb_ifs and the block's top level.
`timescale 1ns / 1ps

module tb_bitmap_first_last_bit_search;
  import bflb_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(9);
  localparam logic [MODE_W-1:0] MODE_FIRST_SET = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_FIRST_CLEAR = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_LAST_SET = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_LAST_CLEAR = MODE_W'(3);

  typedef struct {
    logic signed [LEN_W-1:0] pos;
    logic found;
  } search_result_t;

  logic clk = 1'b0;
  logic rst;

  bflb_in_if bitmap_in ();
  bflb_out_if result_out ();
  bflb_cfg_if cfg ();

  bitmap_first_last_bit_search uut (
    .clk(clk),
    .rst(rst),
    .bitmap_in(bitmap_in.sink),
    .result_out(result_out.source),
    .cfg(cfg.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Search state mirrored from the block.
  logic [MODE_W-1:0] cur_mode = MODE_RESET;
  logic [LEN_W-1:0] cur_len = LEN_RESET;
  int unsigned words_in_bitmap = 0;
  bit match_seen = 1'b0;
  int unsigned match_pos = 0;

  search_result_t pending_results[$];
  int error_count = 0;
  int words_sent = 0;
  int results_checked = 0;
  int stall_cycles = 0;
  bit no_gaps = 1'b0;
  int rx_hold_cycles = 0;

  // Folds one accepted word into the running search and queues a result at the bitmap's end.
  function void predict_search(input logic [WORD_BITS-1:0] word);
    int unsigned len, nwords, base, nvalid;
    logic [WORD_BITS-1:0] mask, hits;
    int unsigned lo, hi;
    search_result_t res;
    len = (cur_len == 0 || cur_len > MAX_BITS) ? MAX_BITS : cur_len;
    nwords = (len + WORD_BITS - 1) / WORD_BITS;
    base = words_in_bitmap * WORD_BITS;
    if (base >= len) nvalid = 0;
    else if (len - base >= WORD_BITS) nvalid = WORD_BITS;
    else nvalid = len - base;
    mask = (nvalid >= WORD_BITS) ? '1 : ((32'd1 << nvalid) - 32'd1);
    hits = (cur_mode[MODE_INVERT_BIT] ? ~word : word) & mask;
    lo = 0;
    hi = 0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (hits[i]) hi = i;
      if (hits[WORD_BITS-1-i]) lo = WORD_BITS - 1 - i;
    end
    if (hits != '0) begin
      if (cur_mode[MODE_LAST_BIT]) begin
        match_pos = base + hi;
        match_seen = 1'b1;
      end else if (!match_seen) begin
        match_pos = base + lo;
        match_seen = 1'b1;
      end
    end
    if (words_in_bitmap + 1 >= nwords) begin
      res.found = match_seen;
      res.pos = match_seen ? LEN_W'(match_pos) : '1;
      pending_results.push_back(res);
      words_in_bitmap = 0;
      match_seen = 1'b0;
      match_pos = 0;
    end else begin
      words_in_bitmap++;
    end
  endfunction

  function automatic logic [WORD_BITS-1:0] random_bitmap_word();
    logic [WORD_BITS-1:0] one_hot;
    one_hot = 32'd1 << $urandom_range(0, WORD_BITS - 1);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return one_hot;
      3: return ~one_hot;
      default: return $urandom;
    endcase
  endfunction

  task send_word(input logic [WORD_BITS-1:0] word);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      bitmap_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    bitmap_in.valid <= 1'b1;
    bitmap_in.bitmap_word <= word;
    do @(posedge clk); while (!bitmap_in.ready);
    predict_search(word);
    words_sent++;
  endtask

  // Stops offering words, waits for every queued result and lets the pipeline empty.
  task wait_results_drained();
    bitmap_in.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task cfg_write_one(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    do @(posedge clk); while (!cfg.ready);
    if (idx == REG_SEARCH_MODE) cur_mode = data[MODE_W-1:0];
    else if (idx == REG_BIT_LENGTH) cur_len = data;
  endtask

  // Upper data bits of the mode write are don't-care and get random values.
  task write_config(input logic [MODE_W-1:0] mode, input logic [LEN_W-1:0] len,
                    input bit touch_unused);
    wait_results_drained();
    cfg_write_one(REG_SEARCH_MODE, {(CFG_DATA_W-MODE_W)'($urandom), mode});
    cfg_write_one(REG_BIT_LENGTH, len);
    if (touch_unused) cfg_write_one(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg.valid <= 1'b0;
  endtask

  // The reset values must already select a first-set search over 1024 bits.
  task test_reset_defaults();
    for (int k = 0; k < MAX_BITS / WORD_BITS; k++)
      send_word(k == 20 ? 32'h0001_0000 : (k > 20 ? random_bitmap_word() : '0));
  endtask

  task test_directed_cases();
    write_config(MODE_FIRST_SET, LEN_W'(1), 1'b1);
    send_word(32'h0000_0001);
    send_word(32'hFFFF_FFFE);
    write_config(MODE_FIRST_CLEAR, LEN_W'(1), 1'b0);
    send_word(32'hFFFF_FFFE);
    send_word(32'h0000_0001);
    write_config(MODE_LAST_SET, LEN_W'(32), 1'b0);
    send_word(32'h8000_0000);
    send_word(32'h0000_0000);
    write_config(MODE_LAST_CLEAR, LEN_W'(32), 1'b0);
    send_word(32'hFFFF_FFFF);
    send_word(32'h7FFF_FFFF);
    // Bit 40 lies past the length and must not match; bit 39 must.
    write_config(MODE_FIRST_SET, LEN_W'(40), 1'b0);
    send_word(32'h0000_0000);
    send_word(32'h0000_0100);
    send_word(32'h0000_0000);
    send_word(32'h0000_0080);
    write_config(MODE_LAST_CLEAR, LEN_W'(40), 1'b0);
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    // A first search keeps its earlier hit; a last search replaces it.
    write_config(MODE_FIRST_SET, LEN_W'(64), 1'b0);
    send_word(32'h0000_0010);
    write_config(MODE_LAST_SET, LEN_W'(64), 1'b0);
    send_word(32'h0000_0001);
    send_word(32'h0000_0010);
    write_config(MODE_FIRST_SET, LEN_W'(64), 1'b0);
    send_word(32'h0000_0001);
    // Shortening the length below the current position ends the bitmap on the next word.
    write_config(MODE_FIRST_SET, LEN_W'(96), 1'b0);
    send_word(32'h0000_0000);
    send_word(32'h0000_0001);
    write_config(MODE_FIRST_SET, LEN_W'(32), 1'b0);
    send_word(32'hFFFF_FFFF);
    write_config(MODE_FIRST_CLEAR, LEN_W'(33), 1'b0);
    send_word(32'hFFFF_FFFF);
    write_config(MODE_FIRST_CLEAR, LEN_W'(64), 1'b0);
    send_word(32'hFFFF_FFFD);
  endtask

  // One-word bitmaps make every word a result, so a stalled receiver backs up the input.
  task test_output_backpressure();
    write_config(MODE_W'($urandom_range(0, 3)), LEN_W'($urandom_range(1, 32)), 1'b0);
    no_gaps = 1'b1;
    rx_hold_cycles = LONG_HOLD_CYCLES;
    for (int k = 0; k < 60; k++) send_word(random_bitmap_word());
    wait_results_drained();
    no_gaps = 1'b0;
  endtask

  task test_random_bitmaps();
    logic [LEN_W-1:0] len;
    logic [MODE_W-1:0] mode;
    int unsigned eff, nwords, items;
    for (int phase = 0; phase < 16; phase++) begin
      case (phase)
        0: len = LEN_W'(1);
        1: len = LEN_W'(MAX_BITS);
        2: len = '0;
        3: len = LEN_W'($urandom_range(MAX_BITS + 1, 2047));
        default: begin
          case ($urandom_range(0, 9))
            0: len = LEN_W'(MAX_BITS);
            1: len = LEN_W'(32);
            2: len = LEN_W'(33);
            default: len = LEN_W'($urandom_range(1, 160));
          endcase
        end
      endcase
      mode = (phase < 4) ? MODE_W'(phase) : MODE_W'($urandom_range(0, 3));
      write_config(mode, len, 1'b0);
      no_gaps = (phase % 5 == 4);
      eff = (len == 0 || len > MAX_BITS) ? MAX_BITS : len;
      nwords = (eff + WORD_BITS - 1) / WORD_BITS;
      items = 0;
      while (items < 90) begin
        for (int k = 0; k < nwords; k++) send_word(random_bitmap_word());
        items += nwords;
      end
      // Sometimes leave a bitmap unfinished so the next settings apply mid-bitmap.
      if (nwords > 1 && $urandom_range(0, 2) == 0)
        for (int k = 0; k < $urandom_range(1, nwords - 1); k++) send_word(random_bitmap_word());
    end
    wait_results_drained();
    no_gaps = 1'b0;
  endtask

  // Result receiver: random stalls, plus one long hold-off when requested.
  initial begin : result_receiver
    int hold;
    wait (!rst);
    @(posedge clk);
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 9);
      if (rx_hold_cycles != 0) begin
        hold = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (hold != 0) begin
        result_out.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      result_out.ready <= 1'b1;
      do @(posedge clk); while (!result_out.valid);
    end
  end

  always @(posedge clk) begin : result_checker
    search_result_t want;
    if (!rst && result_out.valid && result_out.ready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        $error("result with none expected: bit_position %0d, found %0b",
               result_out.bit_position, result_out.found);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_out.bit_position !== want.pos) begin
          $error("bit_position: expected %0d, got %0d", want.pos, result_out.bit_position);
          error_count++;
        end
        if (result_out.found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, result_out.found);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (bitmap_in.valid && bitmap_in.ready) || (result_out.valid && result_out.ready)
        || (cfg.valid && cfg.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("timeout: no handshake for %0d cycles, %0d results outstanding",
             STALL_LIMIT, pending_results.size());
    $display("tb_bitmap_first_last_bit_search failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    bitmap_in.valid = 1'b0;
    bitmap_in.bitmap_word = '0;
    result_out.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_directed_cases();
    test_output_backpressure();
    test_random_bitmaps();
    wait_results_drained();

    $display("%0d bitmap words sent and %0d results checked over all four search modes,",
             words_sent, results_checked);
    $display("lengths from 1 to 1024 plus out-of-range values, with a long output stall.");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb_bitmap_first_last_bit_search passed");
    end else begin
      $display("tb_bitmap_first_last_bit_search failed");
    end
    $finish;
  end

endmodule
